// ----- rtl/core/tvbb_pkg.sv -----
// Shared types and constants for the transformed vertex bounding box unit.
package tvbb_pkg;

  // Field widths fixed by the vertex and box formats.
  localparam int COORD_BITS = 32;
  localparam int COEF_W     = 16;
  localparam int ROW_W      = 3 * COEF_W;
  localparam int CFG_DATA_W = 48;
  localparam int CFG_IDX_W  = 3;

  // Defaults for the top-level parameters.
  localparam int DEF_COEF_FRAC_BITS = 12;
  localparam int DEF_QUEUE_DEPTH    = 4;

  typedef logic signed [COORD_BITS-1:0] coord_t;

  localparam coord_t COORD_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};
  localparam coord_t COORD_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ROW_X   = 3'd0,
    REG_ROW_Y   = 3'd1,
    REG_ROW_Z   = 3'd2,
    REG_SHIFT_X = 3'd3,
    REG_SHIFT_Y = 3'd4,
    REG_SHIFT_Z = 3'd5
  } reg_idx_e;

  // Item class assigned by the front end.
  typedef enum logic {
    KIND_VERTEX = 1'b0,
    KIND_CLOSE  = 1'b1
  } item_kind_e;

  // Input request payload.
  typedef struct packed {
    coord_t pos_x;
    coord_t pos_y;
    coord_t pos_z;
    logic   last;
  } vertex_t;

  // Result payload.
  typedef struct packed {
    coord_t min_x;
    coord_t min_y;
    coord_t min_z;
    coord_t max_x;
    coord_t max_y;
    coord_t max_z;
  } box_t;

  // Entry of the queue between front and back end.
  typedef struct packed {
    item_kind_e kind;
    coord_t     pos_x;
    coord_t     pos_y;
    coord_t     pos_z;
  } queue_item_t;

  // Transform settings handed to the back end.
  typedef struct packed {
    logic [2:0][ROW_W-1:0]      rows;
    logic [2:0][COORD_BITS-1:0] shifts;
  } xform_t;

endpackage

// ----- rtl/core/transformed_vertex_bounding_box_unit.sv -----
// Top level of the transformed vertex bounding box unit.
// Each vertex request is mapped to world space as M * pos + t (Q4.12 coefficients,
// Q16.16 coordinates, rounded and saturated) and folded into per-axis minimum and
// maximum bounds; a request marked last closes the model, yields one box result and
// clears the bounds. The unit takes one vertex per cycle: nine 16x32 multipliers
// work in parallel, and a vertex passes a holding stage, the queue, three transform
// stages and the fold into the result register. The back-end pipeline stalls only
// when a box waits on a full result register; the four-entry queue and the holding
// stage then absorb up to five more requests before the input side stops taking them.
// Configuration writes are always taken and must be made while the unit is idle.
module transformed_vertex_bounding_box_unit import tvbb_pkg::*; #(
  parameter int COEF_FRAC_BITS = DEF_COEF_FRAC_BITS,
  parameter int QUEUE_DEPTH    = DEF_QUEUE_DEPTH
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  vertex_t               in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output box_t                  out_data_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam logic [ROW_W-1:0] ONE_COEF = ROW_W'(1) << COEF_FRAC_BITS;

  logic [ROW_W-1:0]      row_q   [3];
  logic [COORD_BITS-1:0] shift_q [3];
  xform_t                xform;
  logic                  cfg_acc;

  logic        push;
  logic        push_ready;
  queue_item_t push_item;
  logic        pop_valid;
  logic        pop;
  queue_item_t pop_item;

  assign cfg_ready_o = 1'b1;
  assign cfg_acc     = cfg_valid_i & cfg_ready_o;

  // Configuration registers; writes to unknown indexes are dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q[0]   <= ONE_COEF;
      row_q[1]   <= ONE_COEF << COEF_W;
      row_q[2]   <= ONE_COEF << (2 * COEF_W);
      shift_q[0] <= '0;
      shift_q[1] <= '0;
      shift_q[2] <= '0;
    end else if (cfg_acc) begin
      case (reg_idx_e'(cfg_index_i))
        REG_ROW_X:   row_q[0]   <= cfg_data_i[ROW_W-1:0];
        REG_ROW_Y:   row_q[1]   <= cfg_data_i[ROW_W-1:0];
        REG_ROW_Z:   row_q[2]   <= cfg_data_i[ROW_W-1:0];
        REG_SHIFT_X: shift_q[0] <= cfg_data_i[COORD_BITS-1:0];
        REG_SHIFT_Y: shift_q[1] <= cfg_data_i[COORD_BITS-1:0];
        REG_SHIFT_Z: shift_q[2] <= cfg_data_i[COORD_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      xform.rows[a]   = row_q[a];
      xform.shifts[a] = shift_q[a];
    end
  end

  tvbb_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_data_i    (in_data_i),
    .push_o       (push),
    .push_ready_i (push_ready),
    .push_item_o  (push_item)
  );

  tvbb_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_ready_o (push_ready),
    .push_item_i  (push_item),
    .pop_valid_o  (pop_valid),
    .pop_i        (pop),
    .pop_item_o   (pop_item)
  );

  tvbb_back #(
    .COEF_FRAC_BITS (COEF_FRAC_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .xform_i     (xform),
    .q_valid_i   (pop_valid),
    .q_item_i    (pop_item),
    .q_pop_o     (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

// ----- rtl/core/tvbb_front.sv -----
// Front end: accepts vertex requests, classifies them and pushes them to the queue.
module tvbb_front import tvbb_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  vertex_t     in_data_i,
  output logic        push_o,
  input  logic        push_ready_i,
  output queue_item_t push_item_o
);

  logic        hold_valid_q, hold_valid_d;
  queue_item_t hold_q;
  logic        in_acc;
  logic        push_acc;

  // The holding register frees up in the same cycle it drains into the queue.
  assign push_acc   = hold_valid_q & push_ready_i;
  assign in_ready_o = ~hold_valid_q | push_ready_i;
  assign in_acc     = in_valid_i & in_ready_o;

  always_comb begin
    hold_valid_d = hold_valid_q;
    if (push_acc) begin
      hold_valid_d = 1'b0;
    end
    if (in_acc) begin
      hold_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_valid_q <= 1'b0;
    end else begin
      hold_valid_q <= hold_valid_d;
    end
  end

  // Capture and classify: a request marked last closes the current model.
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      hold_q.kind  <= in_data_i.last ? KIND_CLOSE : KIND_VERTEX;
      hold_q.pos_x <= in_data_i.pos_x;
      hold_q.pos_y <= in_data_i.pos_y;
      hold_q.pos_z <= in_data_i.pos_z;
    end
  end

  assign push_o      = hold_valid_q;
  assign push_item_o = hold_q;

endmodule

// ----- rtl/core/tvbb_queue.sv -----
// Short first-in first-out queue that decouples the front end from the back end.
module tvbb_queue import tvbb_pkg::*; #(
  parameter int DEPTH = DEF_QUEUE_DEPTH
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_i,
  output logic        push_ready_o,
  input  queue_item_t push_item_i,
  output logic        pop_valid_o,
  input  logic        pop_i,
  output queue_item_t pop_item_o
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  queue_item_t       mem_q [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic              do_push;
  logic              do_pop;

  assign push_ready_o = (count_q != CNT_W'(DEPTH));
  assign pop_valid_o  = (count_q != '0);
  assign do_push      = push_i & push_ready_o;
  assign do_pop       = pop_i & pop_valid_o;
  assign pop_item_o   = mem_q[rd_ptr_q];

  // Pointer and fill count update; pointers wrap at the depth.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + CNT_W'(1);
    end else if (!do_push && do_pop) begin
      count_d = count_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_item_i;
    end
  end

endmodule

// ----- rtl/core/tvbb_back.sv -----
// Back end: transform pipeline, running bounds and the result register.
module tvbb_back import tvbb_pkg::*; #(
  parameter int COEF_FRAC_BITS = DEF_COEF_FRAC_BITS
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  xform_t      xform_i,
  input  logic        q_valid_i,
  input  queue_item_t q_item_i,
  output logic        q_pop_o,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output box_t        out_data_o
);

  localparam int PROD_W = COORD_BITS + COEF_W;
  localparam int SUM_W  = PROD_W + 2;
  localparam int EXT_W  = SUM_W + 1;

  localparam logic signed [SUM_W-1:0] RND_HALF = SUM_W'(1) <<< (COEF_FRAC_BITS - 1);
  localparam logic signed [EXT_W-1:0] SAT_HI   = (EXT_W'(1) <<< (COORD_BITS - 1)) - EXT_W'(1);
  localparam logic signed [EXT_W-1:0] SAT_LO   = -SAT_HI - EXT_W'(1);

  // Pipeline control.
  logic s1_valid_q, s2_valid_q, s3_valid_q;
  logic s1_last_q, s2_last_q, s3_last_q;
  logic out_valid_q, out_valid_d;
  logic stall;
  logic advance;
  logic close_fire;

  // Datapath.
  coord_t                   pos       [3];
  logic signed [PROD_W-1:0] prod_d    [3][3];
  logic signed [PROD_W-1:0] prod_q    [3][3];
  logic signed [SUM_W-1:0]  rnd_d     [3];
  logic signed [SUM_W-1:0]  rnd_q     [3];
  logic signed [EXT_W-1:0]  moved     [3];
  coord_t                   world_d   [3];
  coord_t                   world_q   [3];
  coord_t                   low_q     [3];
  coord_t                   high_q    [3];
  coord_t                   low_new   [3];
  coord_t                   high_new  [3];
  box_t                     box_d;
  box_t                     out_q;

  // The whole pipeline holds only when a closing item meets a full result register.
  assign stall      = s3_valid_q & s3_last_q & out_valid_q & ~out_ready_i;
  assign advance    = ~stall;
  assign q_pop_o    = advance & q_valid_i;
  assign close_fire = advance & s3_valid_q & s3_last_q;

  assign pos[0] = q_item_i.pos_x;
  assign pos[1] = q_item_i.pos_y;
  assign pos[2] = q_item_i.pos_z;

  // Stage 1: nine coefficient by coordinate products.
  always_comb begin
    for (int a = 0; a < 3; a++) begin
      for (int k = 0; k < 3; k++) begin
        prod_d[a][k] = PROD_W'(signed'(xform_i.rows[a][k*COEF_W +: COEF_W]))
                     * PROD_W'(pos[k]);
      end
    end
  end

  // Stage 2: exact sum, rounded to nearest with ties toward plus infinity.
  always_comb begin
    for (int a = 0; a < 3; a++) begin
      rnd_d[a] = (SUM_W'(prod_q[a][0]) + SUM_W'(prod_q[a][1]) + SUM_W'(prod_q[a][2])
                 + RND_HALF) >>> COEF_FRAC_BITS;
    end
  end

  // Stage 3: add the translation and saturate.
  always_comb begin
    for (int a = 0; a < 3; a++) begin
      moved[a] = EXT_W'(rnd_q[a]) + EXT_W'(signed'(xform_i.shifts[a]));
      if (moved[a] > SAT_HI) begin
        world_d[a] = COORD_MAX;
      end else if (moved[a] < SAT_LO) begin
        world_d[a] = COORD_MIN;
      end else begin
        world_d[a] = coord_t'(moved[a][COORD_BITS-1:0]);
      end
    end
  end

  // Fold the world coordinate into the running bounds.
  always_comb begin
    for (int a = 0; a < 3; a++) begin
      low_new[a]  = (world_q[a] < low_q[a])  ? world_q[a] : low_q[a];
      high_new[a] = (world_q[a] > high_q[a]) ? world_q[a] : high_q[a];
    end
    box_d.min_x = low_new[0];
    box_d.min_y = low_new[1];
    box_d.min_z = low_new[2];
    box_d.max_x = high_new[0];
    box_d.max_y = high_new[1];
    box_d.max_z = high_new[2];
  end

  // Result register: cleared on delivery, loaded when a model closes.
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (close_fire) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      s3_valid_q  <= 1'b0;
      s1_last_q   <= 1'b0;
      s2_last_q   <= 1'b0;
      s3_last_q   <= 1'b0;
      out_valid_q <= 1'b0;
      for (int a = 0; a < 3; a++) begin
        low_q[a]  <= COORD_MAX;
        high_q[a] <= COORD_MIN;
      end
    end else begin
      out_valid_q <= out_valid_d;
      if (advance) begin
        s1_valid_q <= q_valid_i;
        s1_last_q  <= (q_item_i.kind == KIND_CLOSE);
        s2_valid_q <= s1_valid_q;
        s2_last_q  <= s1_last_q;
        s3_valid_q <= s2_valid_q;
        s3_last_q  <= s2_last_q;
        if (s3_valid_q) begin
          for (int a = 0; a < 3; a++) begin
            low_q[a]  <= s3_last_q ? COORD_MAX : low_new[a];
            high_q[a] <= s3_last_q ? COORD_MIN : high_new[a];
          end
        end
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    if (advance) begin
      for (int a = 0; a < 3; a++) begin
        for (int k = 0; k < 3; k++) begin
          prod_q[a][k] <= prod_d[a][k];
        end
        rnd_q[a]   <= rnd_d[a];
        world_q[a] <= world_d[a];
      end
    end
    if (close_fire) begin
      out_q <= box_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ----- rtl/core/tvbb_checker.sv -----
// Port-level checks for the transformed vertex bounding box unit, bound to the top level.
module tvbb_checker import tvbb_pkg::*; (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_ready_o,
  input logic out_valid_o,
  input logic out_ready_i,
  input box_t out_data_o
);

  // A stalled result stays offered.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result request dropped while stalled");

  // A stalled result keeps its box.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(out_data_o))
    else $error("result box changed while stalled");

  // Every box covers at least one vertex, so its bounds are ordered on each axis.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.min_x <= out_data_o.max_x) &&
                    (out_data_o.min_y <= out_data_o.max_y) &&
                    (out_data_o.min_z <= out_data_o.max_z))
    else $error("box minimum above maximum");

  // The input side only fills up right after taking a request.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(in_ready_o) |-> $past(in_valid_i && in_ready_o))
    else $error("input ready fell without a prior request");

endmodule

bind transformed_vertex_bounding_box_unit tvbb_checker u_tvbb_checker (.*);

// ----- test/transformed_vertex_bounding_box_unit_tb.sv -----
// Self-checking testbench for the transformed vertex bounding box unit.
module transformed_vertex_bounding_box_unit_tb import tvbb_pkg::*;;

  localparam int          CLK_HALF      = 10;
  localparam int          COEF_FRAC     = DEF_COEF_FRAC_BITS;
  localparam int          SETTLE_CYCLES = 16;
  localparam int          RANDOM_ITEMS  = 1750;
  localparam int unsigned CYCLE_LIMIT   = 400000;
  localparam logic [COEF_W-1:0] COEF_ONE = COEF_W'(1 << COEF_FRAC);
  localparam logic [COEF_W-1:0] COEF_TOP = {1'b0, {(COEF_W-1){1'b1}}};
  localparam logic [COEF_W-1:0] COEF_BOT = {1'b1, {(COEF_W-1){1'b0}}};
  localparam int          SMALL_SPAN    = 1 << 20;
  // Register indexes past the last register; writes to them must be dropped.
  localparam logic [CFG_IDX_W-1:0] IDX_SPARE_LO = CFG_IDX_W'(REG_SHIFT_Z + 1);
  localparam logic [CFG_IDX_W-1:0] IDX_SPARE_HI = {CFG_IDX_W{1'b1}};

  // Predicts world-space boxes from accepted vertices and checks the results.
  class box_tracker;
    logic [ROW_W-1:0] rows[3];
    coord_t           shifts[3];
    coord_t           low_bound[3];
    coord_t           high_bound[3];
    box_t             expected_boxes[$];
    int               errors;
    int               vertices;
    int               boxes;

    function new();
      rows[0] = ROW_W'(COEF_ONE);
      rows[1] = ROW_W'(COEF_ONE) << COEF_W;
      rows[2] = ROW_W'(COEF_ONE) << (2 * COEF_W);
      foreach (shifts[k]) shifts[k] = '0;
      clear_bounds();
    endfunction

    function void clear_bounds();
      foreach (low_bound[k]) begin
        low_bound[k]  = COORD_MAX;
        high_bound[k] = COORD_MIN;
      end
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_ROW_X, REG_ROW_Y, REG_ROW_Z: begin
          rows[idx] = data[ROW_W-1:0];
        end
        REG_SHIFT_X, REG_SHIFT_Y, REG_SHIFT_Z: begin
          shifts[idx - REG_SHIFT_X] = data[COORD_BITS-1:0];
        end
        default: ;
      endcase
    endfunction

    // Exact dot product, round half up at the coefficient point, add the
    // translation and clamp to the coordinate range.
    function coord_t world_coord(int axis, vertex_t v);
      coord_t pos[3];
      longint acc;
      longint sum;
      pos = '{v.pos_x, v.pos_y, v.pos_z};
      acc = 0;
      for (int k = 0; k < 3; k++) begin
        acc += longint'($signed(rows[axis][k*COEF_W +: COEF_W])) * longint'(pos[k]);
      end
      sum = ((acc + (longint'(1) << (COEF_FRAC - 1))) >>> COEF_FRAC) + longint'(shifts[axis]);
      if (sum > longint'(COORD_MAX)) sum = longint'(COORD_MAX);
      if (sum < longint'(COORD_MIN)) sum = longint'(COORD_MIN);
      return coord_t'(sum);
    endfunction

    function void note_vertex(vertex_t v);
      coord_t w;
      box_t   box;
      vertices++;
      for (int k = 0; k < 3; k++) begin
        w = world_coord(k, v);
        if (w < low_bound[k])  low_bound[k]  = w;
        if (w > high_bound[k]) high_bound[k] = w;
      end
      if (v.last) begin
        box.min_x = low_bound[0];
        box.min_y = low_bound[1];
        box.min_z = low_bound[2];
        box.max_x = high_bound[0];
        box.max_y = high_bound[1];
        box.max_z = high_bound[2];
        expected_boxes = {expected_boxes, box};
        clear_bounds();
      end
    endfunction

    function void check_box(box_t got);
      box_t   want;
      coord_t want_f[6];
      coord_t got_f[6];
      string  names[6] = '{"min_x", "min_y", "min_z", "max_x", "max_y", "max_z"};
      boxes++;
      if (expected_boxes.size() == 0) begin
        $error("box result with no model closed: %p", got);
        errors++;
        return;
      end
      want   = expected_boxes.pop_front();
      want_f = '{want.min_x, want.min_y, want.min_z, want.max_x, want.max_y, want.max_z};
      got_f  = '{got.min_x, got.min_y, got.min_z, got.max_x, got.max_y, got.max_z};
      foreach (names[k]) begin
        if (got_f[k] !== want_f[k]) begin
          $error("%s: expected %0d, got %0d", names[k], want_f[k], got_f[k]);
          errors++;
        end
      end
    endfunction

    function int pending();
      return expected_boxes.size();
    endfunction
  endclass

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  in_valid_i;
  logic                  in_ready_o;
  vertex_t               in_data_i;
  logic                  out_valid_o;
  logic                  out_ready_i;
  box_t                  out_data_o;
  logic                  cfg_valid_i;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  box_tracker  tracker = new();
  logic        quiet;
  int          settings;
  int          model_left;
  int unsigned cycle_count;

  transformed_vertex_bounding_box_unit u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  // Free-running clock.
  always begin
    #CLK_HALF clk_i = 1'b1;
    #CLK_HALF clk_i = 1'b0;
  end

  // Stop a hung run.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("transformed_vertex_bounding_box_unit_tb: done, errors");
      $finish;
    end
  end

  // Check every box taken from the result port.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) tracker.check_box(out_data_o);
  end

  function automatic int draw_gap();
    return quiet ? 0 : int'($urandom_range(0, 3));
  endfunction

  // Result side: stall for a drawn number of cycles before each box.
  initial begin
    out_ready_i = 1'b0;
    @(negedge clk_i);
    while (!rst_ni) @(negedge clk_i);
    forever begin
      int gap;
      gap = draw_gap();
      if (gap != 0) begin
        out_ready_i = 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      out_ready_i = 1'b1;
      do @(posedge clk_i); while (!(out_valid_o && out_ready_i));
      @(negedge clk_i);
    end
  end

  function automatic vertex_t make_vertex(coord_t x, coord_t y, coord_t z, logic last);
    vertex_t v;
    v.pos_x = x;
    v.pos_y = y;
    v.pos_z = z;
    v.last  = last;
    return v;
  endfunction

  function automatic logic [ROW_W-1:0] pack_row(logic [COEF_W-1:0] cx, logic [COEF_W-1:0] cy,
                                                logic [COEF_W-1:0] cz);
    return {cz, cy, cx};
  endfunction

  function automatic logic [COEF_W-1:0] draw_coef();
    case ($urandom_range(0, 7))
      0:       return COEF_TOP;
      1:       return COEF_BOT;
      2:       return '0;
      3:       return COEF_ONE;
      4, 5:    return COEF_W'(int'($urandom_range(0, 4 << COEF_FRAC)) - (2 << COEF_FRAC));
      default: return COEF_W'($urandom);
    endcase
  endfunction

  function automatic coord_t draw_coord();
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 4))
          0:       return COORD_MAX;
          1:       return COORD_MIN;
          2:       return '0;
          3:       return '1;
          default: return coord_t'(1);
        endcase
      end
      1, 2, 3, 4: return coord_t'($urandom);
      default:    return coord_t'(int'($urandom_range(0, 2 * SMALL_SPAN)) - SMALL_SPAN);
    endcase
  endfunction

  // Present one vertex request after a drawn gap and hold it until taken.
  task automatic send_vertex(vertex_t v);
    int gap;
    gap = draw_gap();
    if (gap != 0) begin
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    in_data_i  = v;
    do @(posedge clk_i); while (!in_ready_o);
    tracker.note_vertex(v);
    @(negedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i  = data;
    do @(posedge clk_i); while (!cfg_ready_o);
    tracker.set_reg(idx, data);
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  // Drain all boxes, then let vertices that close no model leave the pipeline.
  task automatic wait_idle();
    in_valid_i = 1'b0;
    while (tracker.pending() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_shift(logic [CFG_IDX_W-1:0] idx, coord_t value);
    // The bits above the coordinate width carry junk that must be ignored.
    write_reg(idx, {16'($urandom), value});
  endtask

  // New random transform; sometimes back to identity, sometimes a dropped write.
  task automatic random_settings();
    settings++;
    wait_idle();
    if ($urandom_range(0, 4) == 0) begin
      write_reg(REG_ROW_X, pack_row(COEF_ONE, '0, '0));
      write_reg(REG_ROW_Y, pack_row('0, COEF_ONE, '0));
      write_reg(REG_ROW_Z, pack_row('0, '0, COEF_ONE));
    end else begin
      write_reg(REG_ROW_X, pack_row(draw_coef(), draw_coef(), draw_coef()));
      write_reg(REG_ROW_Y, pack_row(draw_coef(), draw_coef(), draw_coef()));
      write_reg(REG_ROW_Z, pack_row(draw_coef(), draw_coef(), draw_coef()));
    end
    write_shift(REG_SHIFT_X, $urandom_range(0, 1) ? draw_coord() : '0);
    write_shift(REG_SHIFT_Y, $urandom_range(0, 1) ? draw_coord() : '0);
    write_shift(REG_SHIFT_Z, $urandom_range(0, 1) ? draw_coord() : '0);
    if ($urandom_range(0, 3) == 0) begin
      write_reg($urandom_range(0, 1) ? IDX_SPARE_LO : IDX_SPARE_HI,
                CFG_DATA_W'({$urandom, $urandom}));
    end
    quiet = ($urandom_range(0, 3) == 0);
  endtask

  initial begin
    int sent;
    int phase_len;
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_data_i   = '0;
    cfg_valid_i = 1'b0;
    cfg_index_i = REG_ROW_X;
    cfg_data_i  = '0;
    cycle_count = 0;
    quiet       = 1'b0;
    settings    = 1;
    model_left  = 0;
    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;

    // Reset transform: a single-vertex model and the coordinate extremes.
    send_vertex(make_vertex(COORD_MAX, COORD_MIN, '0, 1'b1));
    send_vertex(make_vertex('0, '0, '0, 1'b0));
    send_vertex(make_vertex(COORD_MIN, COORD_MIN, COORD_MIN, 1'b0));
    send_vertex(make_vertex(COORD_MAX, COORD_MAX, COORD_MAX, 1'b1));

    // Extreme coefficients and translations drive every axis into saturation.
    settings++;
    wait_idle();
    write_reg(REG_ROW_X, pack_row(COEF_BOT, COEF_BOT, COEF_BOT));
    write_reg(REG_ROW_Y, pack_row(COEF_TOP, COEF_TOP, COEF_TOP));
    write_reg(REG_ROW_Z, pack_row(COEF_TOP, COEF_BOT, 16'h0001));
    write_shift(REG_SHIFT_X, COORD_MAX);
    write_shift(REG_SHIFT_Y, COORD_MIN);
    write_shift(REG_SHIFT_Z, draw_coord());
    write_reg(IDX_SPARE_LO, '1);
    write_reg(IDX_SPARE_HI, CFG_DATA_W'({$urandom, $urandom}));
    send_vertex(make_vertex(COORD_MIN, COORD_MIN, COORD_MIN, 1'b0));
    send_vertex(make_vertex(COORD_MAX, COORD_MAX, COORD_MAX, 1'b0));
    send_vertex(make_vertex(COORD_MAX, COORD_MIN, COORD_MAX, 1'b1));
    send_vertex(make_vertex(COORD_MIN, COORD_MIN, COORD_MIN, 1'b1));

    // Smallest coefficient step: exact ties round toward plus infinity.
    settings++;
    wait_idle();
    write_reg(REG_ROW_X, pack_row(16'h0001, '0, '0));
    write_reg(REG_ROW_Y, pack_row('0, '1, '0));
    write_reg(REG_ROW_Z, pack_row('0, '0, 16'h0001));
    write_shift(REG_SHIFT_X, '0);
    write_shift(REG_SHIFT_Y, '0);
    write_shift(REG_SHIFT_Z, '0);
    send_vertex(make_vertex(32'sd2048, 32'sd2048, -32'sd2048, 1'b0));
    send_vertex(make_vertex(-32'sd2048, -32'sd2048, 32'sd2048, 1'b0));
    send_vertex(make_vertex(32'sd6144, -32'sd6144, 32'sd6143, 1'b0));
    send_vertex(make_vertex(-32'sd6144, 32'sd6144, -32'sd6143, 1'b1));
    send_vertex(make_vertex(32'sd2047, 32'sd2049, -32'sd2049, 1'b1));

    // Random models under a series of random transforms; a model may stay
    // open across a settings change and close under the new transform.
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      random_settings();
      phase_len = $urandom_range(40, 120);
      for (int i = 0; i < phase_len; i++) begin
        if (model_left == 0) begin
          model_left = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
        end
        model_left--;
        send_vertex(make_vertex(draw_coord(), draw_coord(), draw_coord(), model_left == 0));
        sent++;
      end
    end

    wait_idle();
    $display("Covered %0d vertex requests under %0d transform settings.",
             tracker.vertices, settings);
    $display("Checked %0d boxes, %0d mismatches.", tracker.boxes, tracker.errors);
    if (tracker.errors == 0 && tracker.pending() == 0) begin
      $display("transformed_vertex_bounding_box_unit_tb: done, clean");
    end else begin
      $display("transformed_vertex_bounding_box_unit_tb: done, errors");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/core/tvbb_pkg.sv
rtl/core/tvbb_front.sv
rtl/core/tvbb_queue.sv
rtl/core/tvbb_back.sv
rtl/core/transformed_vertex_bounding_box_unit.sv
rtl/core/tvbb_checker.sv
test/transformed_vertex_bounding_box_unit_tb.sv
